[sv/scsa_pkg.sv]
// Package for the sensor channel scale and alarm unit: stream field layout,
// item kinds, alarm mode codes and the packed limit decoder. No dependencies.
`default_nettype none

package scsa_pkg;

  // Input tdata layout, lowest bit first
  localparam int unsigned S_TDATA_W    = 96;
  localparam int unsigned CH_W         = 5;
  localparam int unsigned RAW_W        = 16;
  localparam int unsigned LIM_W        = 16;
  localparam int unsigned MODE_W       = 8;
  localparam int unsigned CH_LSB       = 0;
  localparam int unsigned RAW_LSB      = CH_LSB + CH_W;
  localparam int unsigned AHI_LSB      = RAW_LSB + RAW_W;
  localparam int unsigned ALO_LSB      = AHI_LSB + LIM_W;
  localparam int unsigned RHI_LSB      = ALO_LSB + LIM_W;
  localparam int unsigned RLO_LSB      = RHI_LSB + LIM_W;
  localparam int unsigned MODE_LSB     = RLO_LSB + LIM_W;

  // Output layout
  localparam int unsigned M_TDATA_W    = 32;
  localparam int unsigned VAL_W        = 24;
  localparam int unsigned M_TUSER_W    = 2;

  // Scaled product: 15-bit code*5 times 17-bit signed span
  localparam int unsigned PROD_W       = 32;
  localparam int unsigned SCALE_SHIFT  = 14;
  localparam int unsigned CODE_W       = 12;
  localparam int unsigned CODE5_W      = 15;
  localparam int unsigned CNT_W        = 23;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  localparam logic [MODE_W-1:0] MODE_ABOVE   = 8'd1;
  localparam logic [MODE_W-1:0] MODE_BELOW   = 8'd2;
  localparam logic [MODE_W-1:0] MODE_OUTSIDE = 8'd3;

  // Packed limit to hundredths: bits 15..7 are whole units, 6..0 hundredths
  function automatic logic [LIM_W-1:0] decode_limit(input logic [LIM_W-1:0] packed_lim);
    logic [LIM_W-1:0] whole;
    whole = LIM_W'(packed_lim[15:7]) * 16'd100;
    return whole + LIM_W'(packed_lim[6:0]);
  endfunction

endpackage

`default_nettype wire

[sv/sensor_channel_scale_and_alarm_unit.sv]
// Top level of the sensor channel scale and alarm unit: per-channel limit table,
// four-register scaling and alarm pipeline. Depends on scsa_pkg.
`default_nettype none

// Takes one transaction per cycle while s_axis_tready is high and returns exactly
// one result per transaction, in order.
// The pipeline is input register, limit table read and decode, the 15x17 bit
// scaling multiply, then offset, floor, alarm check and the result register;
// empty stages close up so input is still taken while a result waits.
// Load transactions (tuser = 0) write the channel's limits and answer with a zero
// value; a load followed directly by a sample on the same channel is seen by it.
// Limit tables live in flip-flops and are cleared by reset, so there is no
// start-up sweep. cfg_we_i/cfg_wdata_i set limits_valid; write only while idle.
module sensor_channel_scale_and_alarm_unit #(
  parameter int unsigned CHANNELS     = 22,
  parameter int unsigned ADC_CHANNELS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_wdata_i,     // limits_valid
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // channel[4:0], raw_value[20:5], alarm_high_packed[36:21],
  // alarm_low_packed[52:37], range_high_packed[68:53],
  // range_low_packed[84:69], alarm_mode[92:85], zero pad[95:93]
  input  wire logic [scsa_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                            s_axis_tlast,    // end_of_scan
  input  wire logic                            s_axis_tuser,    // kind
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // out_channel[4:0], measured_value[28:5], zero pad[31:29]
  output      logic [scsa_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // channel_alarm[0], scan_alarm[1]
  output      logic [scsa_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

  import scsa_pkg::*;

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [6:0]  CH_LIM  = 7'(CHANNELS);
  localparam logic [6:0]  ADC_LIM = 7'(ADC_CHANNELS);

  // Configuration
  logic limits_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      limits_valid_q <= cfg_wdata_i;
    end
  end

  // Handshake chain
  logic v1_q, v2_q, v3_q, vo_q;
  logic adv1, adv2, adv3, advo;

  assign advo          = !vo_q || m_axis_tready;
  assign adv3          = !v3_q || advo;
  assign adv2          = !v2_q || adv3;
  assign adv1          = !v1_q || adv2;
  assign s_axis_tready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= s_axis_tvalid;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
      if (advo) begin
        vo_q <= v3_q;
      end
    end
  end

  // Stage 1: input register
  logic [S_TDATA_W-1:0] in_data_q;
  logic                 in_eos_q;
  kind_e                in_kind_q;

  always_ff @(posedge clk_i) begin
    if (adv1 && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_eos_q  <= s_axis_tlast;
      in_kind_q <= kind_e'(s_axis_tuser);
    end
  end

  logic [CH_W-1:0]   in_ch;
  logic [RAW_W-1:0]  in_raw;
  logic [LIM_W-1:0]  in_ahi, in_alo, in_rhi, in_rlo;
  logic [MODE_W-1:0] in_mode;
  logic [6:0]        in_ch_ext;
  logic [IDX_W-1:0]  in_idx;
  logic              in_ch_ok;
  logic              in_adc;

  assign in_ch     = in_data_q[CH_LSB +: CH_W];
  assign in_raw    = in_data_q[RAW_LSB +: RAW_W];
  assign in_ahi    = in_data_q[AHI_LSB +: LIM_W];
  assign in_alo    = in_data_q[ALO_LSB +: LIM_W];
  assign in_rhi    = in_data_q[RHI_LSB +: LIM_W];
  assign in_rlo    = in_data_q[RLO_LSB +: LIM_W];
  assign in_mode   = in_data_q[MODE_LSB +: MODE_W];
  assign in_ch_ext = {2'b00, in_ch};
  assign in_idx    = in_ch_ext[IDX_W-1:0];
  assign in_ch_ok  = in_ch_ext < CH_LIM;
  assign in_adc    = in_ch_ext < ADC_LIM;

  // Limit tables, written and read in stage order
  logic [LIM_W-1:0]  ahi_tab_q [CHANNELS];
  logic [LIM_W-1:0]  alo_tab_q [CHANNELS];
  logic [LIM_W-1:0]  rhi_tab_q [CHANNELS];
  logic [LIM_W-1:0]  rlo_tab_q [CHANNELS];
  logic [MODE_W-1:0] mode_tab_q[CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CHANNELS; k++) begin
        ahi_tab_q[k]  <= '0;
        alo_tab_q[k]  <= '0;
        rhi_tab_q[k]  <= '0;
        rlo_tab_q[k]  <= '0;
        mode_tab_q[k] <= '0;
      end
    end else if (v1_q && adv2 && in_kind_q == KIND_LOAD && in_ch_ok) begin
      ahi_tab_q[in_idx]  <= in_ahi;
      alo_tab_q[in_idx]  <= in_alo;
      rhi_tab_q[in_idx]  <= in_rhi;
      rlo_tab_q[in_idx]  <= in_rlo;
      mode_tab_q[in_idx] <= in_mode;
    end
  end

  // Stage 2: decode limits
  logic [LIM_W-1:0]   rmax_dec, rmin_dec;
  logic signed [16:0] span;
  logic [CODE5_W-1:0] code5;
  logic [CNT_W-1:0]   cnt_val;

  assign rmax_dec = decode_limit(rhi_tab_q[in_idx]);
  assign rmin_dec = decode_limit(rlo_tab_q[in_idx]);
  assign span     = $signed({1'b0, rmax_dec}) - $signed({1'b0, rmin_dec});
  assign code5    = CODE5_W'(in_raw[CODE_W-1:0]) * 15'd5;
  assign cnt_val  = CNT_W'(in_raw) * 23'd100;

  logic                s2_sample_q, s2_calc_q, s2_adc_q, s2_eos_q;
  logic [CH_W-1:0]     s2_ch_q;
  logic [LIM_W-1:0]    s2_rmin_q, s2_ahi_q, s2_alo_q;
  logic signed [16:0]  s2_span_q;
  logic [CODE5_W-1:0]  s2_code5_q;
  logic [CNT_W-1:0]    s2_cnt_q;
  logic [MODE_W-1:0]   s2_mode_q;

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      s2_sample_q <= (in_kind_q == KIND_SAMPLE);
      s2_calc_q   <= (in_kind_q == KIND_SAMPLE) && in_ch_ok && limits_valid_q;
      s2_adc_q    <= in_adc;
      s2_eos_q    <= in_eos_q;
      s2_ch_q     <= in_ch;
      s2_rmin_q   <= rmin_dec;
      s2_span_q   <= span;
      s2_code5_q  <= code5;
      s2_cnt_q    <= cnt_val;
      s2_ahi_q    <= decode_limit(ahi_tab_q[in_idx]);
      s2_alo_q    <= decode_limit(alo_tab_q[in_idx]);
      s2_mode_q   <= mode_tab_q[in_idx];
    end
  end

  // Stage 3: scaling multiply
  logic signed [PROD_W-1:0] prod;
  assign prod = $signed(PROD_W'(s2_code5_q)) * PROD_W'(s2_span_q);

  logic                     s3_sample_q, s3_calc_q, s3_adc_q, s3_eos_q;
  logic [CH_W-1:0]          s3_ch_q;
  logic [LIM_W-1:0]         s3_rmin_q, s3_ahi_q, s3_alo_q;
  logic signed [PROD_W-1:0] s3_prod_q;
  logic [CNT_W-1:0]         s3_cnt_q;
  logic [MODE_W-1:0]        s3_mode_q;

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      s3_sample_q <= s2_sample_q;
      s3_calc_q   <= s2_calc_q;
      s3_adc_q    <= s2_adc_q;
      s3_eos_q    <= s2_eos_q;
      s3_ch_q     <= s2_ch_q;
      s3_rmin_q   <= s2_rmin_q;
      s3_prod_q   <= prod;
      s3_cnt_q    <= s2_cnt_q;
      s3_ahi_q    <= s2_ahi_q;
      s3_alo_q    <= s2_alo_q;
      s3_mode_q   <= s2_mode_q;
    end
  end

  // Stage 4: offset, floor, alarm rule, scan alarm
  logic signed [PROD_W-1:0] prod_floor;
  logic signed [VAL_W-1:0]  adc_val, meas_val, ahi_s, alo_s;
  logic                     above, below, alarm;
  logic                     seen_q, seen_next, scan;

  assign prod_floor = s3_prod_q >>> SCALE_SHIFT;
  assign adc_val    = $signed({8'd0, s3_rmin_q}) + VAL_W'(prod_floor);
  assign ahi_s      = $signed({8'd0, s3_ahi_q});
  assign alo_s      = $signed({8'd0, s3_alo_q});

  always_comb begin
    if (!s3_calc_q) begin
      meas_val = '0;
    end else if (s3_adc_q) begin
      meas_val = adc_val;
    end else begin
      meas_val = $signed({1'b0, s3_cnt_q});
    end
    above = meas_val > ahi_s;
    below = meas_val < ahi_s;
    alarm = 1'b0;
    if (s3_calc_q) begin
      unique case (s3_mode_q)
        MODE_ABOVE:   alarm = above;
        MODE_BELOW:   alarm = below;
        MODE_OUTSIDE: alarm = above || (meas_val < alo_s);
        default:      alarm = 1'b0;
      endcase
    end
    seen_next = seen_q || alarm;
    scan      = s3_sample_q && s3_eos_q && seen_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (advo && v3_q && s3_sample_q) begin
      seen_q <= s3_eos_q ? 1'b0 : seen_next;
    end
  end

  // Result register
  logic [CH_W-1:0]  out_ch_q;
  logic [VAL_W-1:0] out_val_q;
  logic             out_alarm_q, out_scan_q;

  always_ff @(posedge clk_i) begin
    if (advo && v3_q) begin
      out_ch_q    <= s3_ch_q;
      out_val_q   <= meas_val;
      out_alarm_q <= alarm;
      out_scan_q  <= scan;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {(M_TDATA_W - VAL_W - CH_W)'(0), out_val_q, out_ch_q};
  assign m_axis_tuser  = {out_scan_q, out_alarm_q};

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for sensor_channel_scale_and_alarm_unit: stream driver and
// monitor, in-order prediction of scaled readings, channel and scan alarms.
// Depends on scsa_pkg and the unit's top level; needs no files or arguments.
`default_nettype none

module testbench;
  import scsa_pkg::*;

  localparam int unsigned NUM_CH       = 22;
  localparam int unsigned NUM_ADC      = 16;
  localparam int unsigned LIMIT_CYCLES = 100000;
  localparam int unsigned IDLE_PCT     = 27;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned HOLD_AFTER   = 600;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct {
    kind_e             kind;
    logic [CH_W-1:0]   channel;
    logic [RAW_W-1:0]  raw;
    logic              eos;
    logic [LIM_W-1:0]  ahi;
    logic [LIM_W-1:0]  alo;
    logic [LIM_W-1:0]  rhi;
    logic [LIM_W-1:0]  rlo;
    logic [MODE_W-1:0] mode;
  } channel_item_t;

  typedef struct {
    logic [CH_W-1:0]  channel;
    logic [VAL_W-1:0] value;
    logic             alarm;
    logic             scan;
  } reading_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic                 cfg_wdata_i   = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  sensor_channel_scale_and_alarm_unit #(
    .CHANNELS    (NUM_CH),
    .ADC_CHANNELS(NUM_ADC)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow of the unit's limit tables and scan state
  logic [LIM_W-1:0]  alarm_hi_mem [NUM_CH];
  logic [LIM_W-1:0]  alarm_lo_mem [NUM_CH];
  logic [LIM_W-1:0]  range_hi_mem [NUM_CH];
  logic [LIM_W-1:0]  range_lo_mem [NUM_CH];
  logic [MODE_W-1:0] mode_mem     [NUM_CH];
  logic              scan_alarm_pending;
  logic              limits_in_force;

  channel_item_t pending_items[$];
  reading_t      expected_readings[$];
  channel_item_t held_item;
  reading_t      next_reading;
  reading_t      want;
  logic          steady = 1'b0;
  int unsigned   failures, cycles, readings_checked, hold_left;
  int unsigned   n_loads, n_samples, n_alarms, n_scan_alarms;
  logic          hold_done = 1'b0;

  function automatic longint hundredths(logic [LIM_W-1:0] code_word);
    return longint'(code_word[15:7]) * 100 + longint'(code_word[6:0]);
  endfunction

  function automatic reading_t scale_and_check(channel_item_t it);
    reading_t r;
    longint   ahigh, alow, rmax, rmin, val;
    logic     alarm;
    val       = 0;
    alarm     = 1'b0;
    r.channel = it.channel;
    r.scan    = 1'b0;
    if (it.kind == KIND_LOAD) begin
      if (it.channel < NUM_CH) begin
        alarm_hi_mem[it.channel] = it.ahi;
        alarm_lo_mem[it.channel] = it.alo;
        range_hi_mem[it.channel] = it.rhi;
        range_lo_mem[it.channel] = it.rlo;
        mode_mem[it.channel]     = it.mode;
      end
    end else begin
      if (it.channel < NUM_CH && limits_in_force) begin
        ahigh = hundredths(alarm_hi_mem[it.channel]);
        alow  = hundredths(alarm_lo_mem[it.channel]);
        if (it.channel < NUM_ADC) begin
          rmax = hundredths(range_hi_mem[it.channel]);
          rmin = hundredths(range_lo_mem[it.channel]);
          // arithmetic shift floors, so inverted ranges round downward
          val  = rmin + ((longint'(it.raw[CODE_W-1:0]) * (rmax - rmin) * 5) >>> SCALE_SHIFT);
        end else begin
          val = longint'(it.raw) * 100;
        end
        case (mode_mem[it.channel])
          MODE_ABOVE:   alarm = val > ahigh;
          MODE_BELOW:   alarm = val < ahigh;
          MODE_OUTSIDE: alarm = (val > ahigh) || (val < alow);
          default:      alarm = 1'b0;
        endcase
      end
      if (alarm) scan_alarm_pending = 1'b1;
      if (it.eos) begin
        r.scan             = scan_alarm_pending;
        scan_alarm_pending = 1'b0;
      end
    end
    r.value = val[VAL_W-1:0];
    r.alarm = alarm;
    return r;
  endfunction

  function automatic channel_item_t load_item(int unsigned ch, logic [LIM_W-1:0] ahi, alo,
                                              rhi, rlo, logic [MODE_W-1:0] mode,
                                              logic eos = 1'b0);
    channel_item_t it;
    it.kind    = KIND_LOAD;
    it.channel = CH_W'(ch);
    it.raw     = '0;
    it.eos     = eos;
    it.ahi     = ahi;
    it.alo     = alo;
    it.rhi     = rhi;
    it.rlo     = rlo;
    it.mode    = mode;
    return it;
  endfunction

  function automatic channel_item_t sample_item(int unsigned ch, logic [RAW_W-1:0] raw,
                                                logic eos = 1'b0);
    channel_item_t it;
    it         = load_item(ch, '0, '0, '0, '0, '0, eos);
    it.kind    = KIND_SAMPLE;
    it.raw     = raw;
    return it;
  endfunction

  function automatic channel_item_t random_item(int unsigned load_pct);
    channel_item_t it;
    it.kind    = ($urandom_range(99) < load_pct) ? KIND_LOAD : KIND_SAMPLE;
    it.channel = ($urandom_range(19) == 0) ? CH_W'($urandom_range(31, NUM_CH))
                                           : CH_W'($urandom_range(NUM_CH - 1));
    it.raw     = RAW_W'($urandom);
    // counter readings only meet the limits for small counts
    if (it.kind == KIND_SAMPLE && it.channel >= NUM_ADC && $urandom_range(9) < 7)
      it.raw = RAW_W'($urandom_range(600));
    it.eos     = ($urandom_range(7) == 0);
    it.ahi     = LIM_W'($urandom);
    it.alo     = LIM_W'($urandom);
    it.rhi     = LIM_W'($urandom);
    it.rlo     = LIM_W'($urandom);
    it.mode    = ($urandom_range(4) == 0) ? MODE_W'($urandom) : MODE_W'($urandom_range(3, 1));
    return it;
  endfunction

  function automatic logic [S_TDATA_W-1:0] pack_item(channel_item_t it);
    logic [S_TDATA_W-1:0] d;
    d                      = '0;
    d[CH_LSB   +: CH_W]    = it.channel;
    d[RAW_LSB  +: RAW_W]   = it.raw;
    d[AHI_LSB  +: LIM_W]   = it.ahi;
    d[ALO_LSB  +: LIM_W]   = it.alo;
    d[RHI_LSB  +: LIM_W]   = it.rhi;
    d[RLO_LSB  +: LIM_W]   = it.rlo;
    d[MODE_LSB +: MODE_W]  = it.mode;
    return d;
  endfunction

  task automatic queue_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) pending_items.push_back(random_item(15));
  endtask

  task automatic write_limits_valid(logic v);
    @(posedge clk_i);
    cfg_we_i        <= 1'b1;
    cfg_wdata_i     <= v;
    limits_in_force  = v;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_readings.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Driver: predicts at acceptance, then offers the next transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        next_reading = scale_and_check(held_item);
        expected_readings.push_back(next_reading);
        if (held_item.kind == KIND_LOAD) n_loads++;
        else n_samples++;
        n_alarms      += next_reading.alarm;
        n_scan_alarms += next_reading.scan;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          held_item      = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pack_item(held_item);
          s_axis_tlast  <= held_item.eos;
          s_axis_tuser  <= held_item.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        readings_checked++;
        if (expected_readings.size() == 0) begin
          $display("%0t: result with nothing expected, tdata %h tuser %b",
                   $time, m_axis_tdata, m_axis_tuser);
          failures++;
        end else begin
          want = expected_readings.pop_front();
          if (m_axis_tdata[CH_LSB +: CH_W] !== want.channel) begin
            $display("%0t: channel expected %0d actual %0d", $time, want.channel,
                     m_axis_tdata[CH_LSB +: CH_W]);
            failures++;
          end
          if (m_axis_tdata[CH_W +: VAL_W] !== want.value) begin
            $display("%0t: ch %0d value expected %0d actual %0d", $time, want.channel,
                     $signed(want.value), $signed(m_axis_tdata[CH_W +: VAL_W]));
            failures++;
          end
          if (m_axis_tuser[0] !== want.alarm) begin
            $display("%0t: ch %0d channel alarm expected %b actual %b", $time, want.channel,
                     want.alarm, m_axis_tuser[0]);
            failures++;
          end
          if (m_axis_tuser[1] !== want.scan) begin
            $display("%0t: ch %0d scan alarm expected %b actual %b", $time, want.channel,
                     want.scan, m_axis_tuser[1]);
            failures++;
          end
        end
      end
      // one long back-pressure stretch so the pipeline fills and stalls its input
      if (!hold_done && readings_checked >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("[sensor_channel_scale_and_alarm_unit] ERROR");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < NUM_CH; k++) begin
      alarm_hi_mem[k] = '0;
      alarm_lo_mem[k] = '0;
      range_hi_mem[k] = '0;
      range_lo_mem[k] = '0;
      mode_mem[k]     = '0;
    end
    scan_alarm_pending = 1'b0;
    limits_in_force    = 1'b0;
    failures           = 0;
    cycles             = 0;
    readings_checked   = 0;
    hold_left          = 0;
    n_loads            = 0;
    n_samples          = 0;
    n_alarms           = 0;
    n_scan_alarms      = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // limits not in force: tables still load, readings stay zero
    pending_items.push_back(load_item(0, 16'h3200, 16'h0A00, 16'hFFFF, 16'h0000, MODE_ABOVE));
    pending_items.push_back(sample_item(0, 16'h0FFF));
    pending_items.push_back(sample_item(16, 16'hFFFF, 1'b1));
    wait_idle();
    write_limits_valid(1'b1);

    // full-scale ADC range, code extremes, upper raw bits ignored
    pending_items.push_back(sample_item(0, 16'h0000));
    pending_items.push_back(sample_item(0, 16'hFFFF));
    pending_items.push_back(sample_item(0, 16'h7000, 1'b1));
    // inverted range, below-high rule
    pending_items.push_back(load_item(1, 16'h3200, 16'h0000, 16'h0000, 16'hFFFF, MODE_BELOW));
    pending_items.push_back(sample_item(1, 16'h0001));
    pending_items.push_back(sample_item(1, 16'h0FFF));
    // window rule on the last converter channel
    pending_items.push_back(load_item(15, 16'h6400, 16'h3200, 16'h9600, 16'h0000,
                                      MODE_OUTSIDE));
    pending_items.push_back(sample_item(15, 16'h0400));
    pending_items.push_back(sample_item(15, 16'h0C00));
    pending_items.push_back(sample_item(15, 16'h0800, 1'b1));
    // first counter channel; end of scan on a load is ignored
    pending_items.push_back(load_item(16, 16'h3200, 16'h0A00, 16'hFFFF, 16'hFFFF,
                                      MODE_OUTSIDE, 1'b1));
    pending_items.push_back(sample_item(16, 16'h0000));
    pending_items.push_back(sample_item(16, 16'd50));
    pending_items.push_back(sample_item(16, 16'hFFFF, 1'b1));
    // unknown mode never alarms
    pending_items.push_back(load_item(21, 16'h007F, 16'hFF80, 16'hFFFF, 16'h0000, 8'hFF));
    pending_items.push_back(sample_item(21, 16'h0400, 1'b1));
    // channels beyond the table: load dropped, sample zero, scan still reported
    pending_items.push_back(load_item(22, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
                                      MODE_ABOVE));
    pending_items.push_back(sample_item(22, 16'hFFFF));
    pending_items.push_back(load_item(31, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    pending_items.push_back(sample_item(0, 16'h0FFF));
    pending_items.push_back(sample_item(31, 16'hFFFF, 1'b1));
    // mode zero, and a sample right behind its own load
    pending_items.push_back(load_item(2, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 8'h00));
    pending_items.push_back(sample_item(2, 16'h0ABC, 1'b1));
    wait_idle();

    for (int unsigned ch = 0; ch < NUM_CH; ch++) begin
      held_item         = random_item(100);
      held_item.channel = CH_W'(ch);
      pending_items.push_back(held_item);
    end
    queue_random(800);
    wait_idle();

    steady = 1'b1;
    queue_random(300);
    wait_idle();
    steady = 1'b0;

    write_limits_valid(1'b0);
    queue_random(150);
    wait_idle();

    write_limits_valid(1'b1);
    queue_random(650);
    wait_idle();

    $display("Run covered %0d limit loads and %0d samples over converter, counter and",
             n_loads, n_samples);
    $display("out-of-table channels, with limits on and off: %0d channel alarms, %0d scan alarms",
             n_alarms, n_scan_alarms);
    if (failures == 0) begin
      $display("[sensor_channel_scale_and_alarm_unit] OK");
    end else begin
      $display("[sensor_channel_scale_and_alarm_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/scsa_pkg.sv
sv/sensor_channel_scale_and_alarm_unit.sv
tb/testbench.sv
